[hw/rtl/utf8bs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8bs_pkg
// Shared types, constants and the lead-byte decoder of the block segmenter.
// ----------------------------------------------------------------------------
package utf8bs_pkg;

    localparam int DEFAULT_BLOCK_CHARS = 8;
    localparam int LINE_INDEX_BITS     = 8;

    typedef logic [LINE_INDEX_BITS-1:0] t_idx;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int   APB_ADDR_W = 3;
    localparam logic REG_TPB    = 1'b0;

    // One run of characters produced by one input item: the first character
    // has first_len bytes, every further one a single byte.
    typedef struct packed {
        logic [2:0] first_len;
        logic [2:0] n_chars;
        logic       eol;
    } t_char_run;

    typedef struct packed {
        logic      valid;
        t_char_run run;
    } t_q_head;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd1;
        if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
        else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
        return len;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/utf8_block_segmenter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_block_segmenter
// Split a byte stream of text lines into UTF-8 characters and report blocks.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the queue has room (tlast marks
// the last byte of a line) and reports one output item per block of
// tokens_per_block characters (zero selects 8), with the line's last block
// flagged by tlast. The front end classifies every byte combinationally; the
// back end counts one character per cycle while the output is free, and a
// byte that flushes a broken sequence yields up to four characters, absorbed
// by a four-entry queue of character runs. Results leave through an output
// register, and a stalled output holds the back end while bytes keep
// flowing into the queue.
module utf8_block_segmenter
    import utf8bs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // byte_value
    input  wire logic                  s_tlast,   // end_of_line
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // block_start, block_bytes,
                                                  // block_column, block_chars
    output logic                       m_tlast,   // final_block
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [7:0] r_tpb;
    logic [7:0] limit;
    logic       cfg_wr;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    t_char_run  q_run;
    t_q_head    q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_TPB);
    assign prdata = (paddr[APB_ADDR_W-1] == REG_TPB) ? {24'd0, r_tpb} : 32'd0;
    assign limit  = (r_tpb != 8'd0) ? r_tpb : 8'(DEFAULT_BLOCK_CHARS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpb <= 8'd0;
        end else if (cfg_wr) begin
            r_tpb <= pwdata[7:0];
        end
    end

    utf8bs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_byte  (s_tdata),
        .i_eol   (s_tlast),
        .i_full  (q_full),
        .o_ready (s_tready),
        .o_push  (q_push),
        .o_run   (q_run)
    );

    utf8bs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_run   (q_run),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    utf8bs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_limit    (limit),
        .o_pop      (q_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    a_chars_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[31:24] != 8'd0))
        else $error("block reported with no characters");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

    a_eol_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tlast) |-> q_push)
        else $error("line end item produced no characters");

endmodule
`default_nettype wire

[hw/rtl/utf8bs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8bs_front
// Accept bytes, track an open multi-byte sequence and turn each item into a
// run of finished characters for the back end.
// ----------------------------------------------------------------------------
module utf8bs_front
    import utf8bs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eol,
    input  wire logic       i_full,
    output logic            o_ready,
    output logic            o_push,
    output t_char_run       o_run
);

    logic [1:0] r_pend, n_pend;
    logic [2:0] r_exp,  n_exp;
    logic       is_cont;
    logic [2:0] lead;
    logic [2:0] pend_inc;
    logic [2:0] nch;
    logic [2:0] first;
    logic       fresh;
    logic       accept;

    always_comb begin
        is_cont  = (i_byte & CONT_MASK) == CONT_TAG;
        lead     = lead_length(i_byte);
        pend_inc = {1'b0, r_pend} + 3'd1;
        n_pend   = r_pend;
        n_exp    = r_exp;
        nch      = 3'd0;
        first    = 3'd1;
        fresh    = 1'b1;
        if (r_pend != 2'd0) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (pend_inc >= r_exp) begin
                    nch    = 3'd1;
                    first  = r_exp;
                    n_pend = 2'd0;
                    n_exp  = 3'd0;
                end else begin
                    n_pend = pend_inc[1:0];
                end
            end else begin
                // broken sequence: flush held bytes as single characters
                nch    = {1'b0, r_pend};
                n_pend = 2'd0;
                n_exp  = 3'd0;
            end
        end
        if (fresh) begin
            if (lead > 3'd1) begin
                n_pend = 2'd1;
                n_exp  = lead;
            end else begin
                nch = nch + 3'd1;
            end
        end
        if (i_eol) begin
            nch    = nch + {1'b0, n_pend};
            n_pend = 2'd0;
            n_exp  = 3'd0;
        end
    end

    assign o_ready         = !i_full;
    assign accept          = i_valid && o_ready;
    assign o_push          = accept && (nch != 3'd0);
    assign o_run.first_len = first;
    assign o_run.n_chars   = nch;
    assign o_run.eol       = i_eol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_exp  <= 3'd0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_exp  <= n_exp;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/utf8bs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8bs_queue
// Short FIFO of character runs between the front and the back end.
// ----------------------------------------------------------------------------
module utf8bs_queue
    import utf8bs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_char_run i_run,
    input  wire logic      i_pop,
    output logic           o_full,
    output t_q_head        o_head
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_char_run         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full       = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_head.valid = r_cnt != '0;
    assign o_head.run   = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + QPTR_W'(1);
            if (do_pop)  r_rd <= r_rd + QPTR_W'(1);
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/utf8bs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8bs_back
// Step through queued characters one per cycle while the output register is
// free, count them into blocks and register each closed block on the output channel.
// ----------------------------------------------------------------------------
module utf8bs_back
    import utf8bs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_q_head     i_head,
    input  wire logic [7:0]  i_limit,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,
    output logic             o_m_tlast
);

    t_idx       r_off, r_bstart, r_col;
    logic [7:0] r_chars;
    logic [1:0] r_ci;
    logic       r_ovalid;
    logic [31:0] r_odata;
    logic       r_olast;

    logic       out_free;
    logic       step;
    logic [2:0] len;
    t_idx       pos;
    logic [7:0] chars_n;
    logic       last;
    logic       line_end;
    logic       close;

    assign out_free = !r_ovalid || i_m_tready;
    assign step     = i_head.valid && out_free;
    assign len      = (r_ci == 2'd0) ? i_head.run.first_len : 3'd1;
    assign pos      = r_off + t_idx'(len);
    assign chars_n  = r_chars + 8'd1;
    assign last     = {1'b0, r_ci} == (i_head.run.n_chars - 3'd1);
    assign line_end = i_head.run.eol && last;
    assign close    = (chars_n >= i_limit) || line_end;
    assign o_pop    = step && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off    <= '0;
            r_bstart <= '0;
            r_col    <= '0;
            r_chars  <= '0;
            r_ci     <= '0;
        end else if (step) begin
            r_ci <= last ? 2'd0 : r_ci + 2'd1;
            priority if (line_end) begin
                r_off    <= '0;
                r_bstart <= '0;
                r_col    <= '0;
                r_chars  <= '0;
            end else if (close) begin
                r_off    <= pos;
                r_bstart <= pos;
                r_col    <= r_col + t_idx'(chars_n);
                r_chars  <= '0;
            end else begin
                r_off   <= pos;
                r_chars <= chars_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (step && close) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && close) begin
            r_odata <= {chars_n, 8'(r_col), 8'(pos - r_bstart), 8'(r_bstart)};
            r_olast <= line_end;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_block_segmenter: text lines of well-formed and
// broken UTF-8 go in through the byte stream, and a predictor in a small
// scoreboard works out the expected block items and compares each one as it
// leaves. The block count is reprogrammed over APB between drained phases.
// ----------------------------------------------------------------------------
module tb;
    import utf8bs_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 32;
    localparam int RANDOM_ITEMS    = 110;
    localparam int PHASE_ITEMS     = 24;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        t_idx       start;
        logic [7:0] nbytes;
        t_idx       column;
        logic [7:0] nchars;
        logic       last;
    } t_blk;

    class block_scoreboard;
        logic [7:0] tokens_cfg;
        int         held_cnt;
        int         seq_len;
        t_idx       line_off;
        t_idx       blk_start;
        t_idx       line_col;
        int         chars_in_blk;
        t_blk       expected_blocks[$];
        int         errors;

        function new();
            errors = 0;
            tokens_cfg = 8'd0;
            clear_line();
        endfunction

        function void clear_line();
            held_cnt = 0;
            seq_len = 0;
            line_off = '0;
            blk_start = '0;
            line_col = '0;
            chars_in_blk = 0;
        endfunction

        function int seq_length(logic [7:0] b);
            if (b >= LEAD2_LO && b <= LEAD2_HI) return 2;
            if (b >= LEAD3_LO && b <= LEAD3_HI) return 3;
            if (b >= LEAD4_LO && b <= LEAD4_HI) return 4;
            return 1;
        endfunction

        function void push_block(t_idx end_pos, logic last);
            t_blk e;
            e.start  = blk_start;
            e.nbytes = 8'(end_pos - blk_start);
            e.column = line_col;
            e.nchars = 8'(chars_in_blk);
            e.last   = last;
            expected_blocks.push_back(e);
        endfunction

        function void note_byte(logic [7:0] b, logic eol);
            int   lens[4];
            int   nch;
            int   lim;
            int   len;
            bit   fresh;
            t_idx pos;
            nch = 0;
            fresh = 1'b1;
            lim = (tokens_cfg != 8'd0) ? int'(tokens_cfg) : DEFAULT_BLOCK_CHARS;
            if (held_cnt > 0) begin
                if ((b & CONT_MASK) == CONT_TAG) begin
                    held_cnt++;
                    fresh = 1'b0;
                    if (held_cnt >= seq_len) begin
                        lens[nch] = seq_len;
                        nch++;
                        held_cnt = 0;
                        seq_len = 0;
                    end
                end else begin
                    // flush the broken sequence as single-byte characters
                    while (held_cnt > 0 && nch < 3) begin
                        lens[nch] = 1;
                        nch++;
                        held_cnt--;
                    end
                    held_cnt = 0;
                    seq_len = 0;
                end
            end
            if (fresh) begin
                len = seq_length(b);
                if (len > 1) begin
                    held_cnt = 1;
                    seq_len = len;
                end else begin
                    lens[nch] = 1;
                    nch++;
                end
            end
            if (eol) begin
                while (held_cnt > 0 && nch < 4) begin
                    lens[nch] = 1;
                    nch++;
                    held_cnt--;
                end
                held_cnt = 0;
                seq_len = 0;
            end
            pos = line_off;
            for (int i = 0; i < nch; i++) begin
                pos = pos + t_idx'(lens[i]);
                chars_in_blk++;
                if (chars_in_blk >= lim) begin
                    push_block(pos, eol && (i == nch - 1));
                    line_col = line_col + t_idx'(chars_in_blk);
                    blk_start = pos;
                    chars_in_blk = 0;
                end
            end
            line_off = pos;
            if (eol) begin
                if (chars_in_blk > 0) push_block(pos, 1'b1);
                clear_line();
            end
        endfunction

        function void compare(string name, int expv, int actv);
            if (expv != actv) begin
                $error("%s: expected %0d, got %0d", name, expv, actv);
                errors++;
            end
        endfunction

        function void check_block(logic [31:0] d, logic last);
            t_blk e;
            if (expected_blocks.size() == 0) begin
                $error("unexpected block item: tdata=%h tlast=%b", d, last);
                errors++;
                return;
            end
            e = expected_blocks.pop_front();
            compare("block_start", e.start, d[7:0]);
            compare("block_bytes", e.nbytes, d[15:8]);
            compare("block_column", e.column, d[23:16]);
            compare("block_chars", e.nchars, d[31:24]);
            compare("final_block", e.last, last);
        endfunction
    endclass

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'd0;   // byte_value
    logic                  s_tlast  = 1'b0;   // end_of_line
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;           // block_start, block_bytes,
                                              // block_column, block_chars
    logic                  m_tlast;           // final_block
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = 32'd0;
    logic [31:0]           prdata;
    logic                  pready;

    block_scoreboard sb = new();
    logic [8:0]      stim[$];
    int              burst_left = 0;
    int              n_sent = 0;
    bit              hold_off_req = 1'b0;

    utf8_block_segmenter i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_block(m_tdata, m_tlast);
    end

    initial begin
        int mode;
        int cnt;
        mode = 0;
        cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                // hold off long enough for the block to back up its input
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (cnt == 0) begin
                    mode = $urandom_range(0, 3);
                    cnt = $urandom_range(16, 96);
                end
                cnt--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (cnt % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eol);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_byte(b, eol);
        burst_left--;
        n_sent++;
    endtask

    task automatic send_stim();
        while (stim.size() != 0) begin
            logic [8:0] w;
            w = stim.pop_front();
            send_byte(w[7:0], w[8]);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tokens(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_TPB);
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.tokens_cfg = v;
    endtask

    function automatic void put(input logic [7:0] b);
        stim.push_back({1'b0, b});
    endfunction

    function automatic void mark_eol();
        stim[stim.size() - 1][8] = 1'b1;
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2: return 8'($urandom_range(LEAD2_LO, LEAD2_HI));
            3: return 8'($urandom_range(LEAD3_LO, LEAD3_HI));
            default: return 8'($urandom_range(LEAD4_LO, LEAD4_HI));
        endcase
    endfunction

    function automatic void put_partial_seq();
        int len;
        int n;
        len = $urandom_range(2, 4);
        put(lead_byte(len));
        n = $urandom_range(0, len - 2);
        repeat (n) put(cont_byte());
    endfunction

    function automatic void build_line(input int nchars, input bit end_line);
        int         r;
        int         len;
        logic [7:0] b;
        for (int c = 0; c < nchars; c++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                put(8'($urandom_range(0, 127)));
            end else if (r < 78) begin
                len = (r < 55) ? 2 : (r < 68) ? 3 : 4;
                put(lead_byte(len));
                repeat (len - 1) put(cont_byte());
            end else if (r < 84) begin
                put(cont_byte());
            end else if (r < 88) begin
                b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'hC0, 8'hC1))
                                                : 8'($urandom_range(8'hF5, 8'hFF));
                put(b);
            end else if (r < 96) begin
                // break the sequence with a byte that is no continuation
                put_partial_seq();
                b = 8'($urandom_range(0, 255));
                if ((b & CONT_MASK) == CONT_TAG) b = b ^ 8'h40;
                put(b);
            end else begin
                put(8'($urandom_range(0, 255)));
            end
        end
        if (end_line) begin
            if ($urandom_range(0, 4) == 0) put_partial_seq();
            mark_eol();
        end
    endfunction

    function automatic logic [7:0] phase_tokens(input int p);
        case (p % 6)
            0: return 8'd1;
            1: return 8'd0;
            2: return 8'd255;
            3: return 8'($urandom_range(2, 16));
            4: return 8'd2;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    initial begin
        int base;
        int phase;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count: NUL line, invalid lead line, then a mixed line
        put(8'h00); mark_eol();
        put(8'hFF); mark_eol();
        put(8'h7F); put(8'h80); put(8'hC0);
        put(8'hC2); put(8'hBF);
        put(8'hE0); put(8'h80); put(8'h80);
        put(8'hEF); put(8'hBF); put(8'hBF);
        put(8'hF0); put(8'h80); put(8'h80); put(8'h80);
        put(8'hF4); put(8'h8F); put(8'hBF); put(8'h41);
        put(8'hF4); put(8'h80); mark_eol();
        send_stim();
        drain();

        // one character per block: broken sequence gives four blocks at once
        write_tokens(8'd1);
        put(8'hF4); put(8'h8F); put(8'hBF); put(8'h41); mark_eol();
        send_stim();
        drain();

        // shrink the count inside an open block
        write_tokens(8'd255);
        repeat (5) put(8'($urandom_range(8'h20, 8'h7E)));
        send_stim();
        drain();
        write_tokens(8'd2);
        put(8'h78); mark_eol();
        send_stim();
        drain();

        // a block of exactly 256 bytes wraps the byte count
        write_tokens(8'd128);
        repeat (128) begin
            put(8'hC3);
            put(8'hA9);
        end
        mark_eol();
        send_stim();

        base = n_sent;
        phase = 0;
        while (n_sent - base < RANDOM_ITEMS) begin
            drain();
            write_tokens(phase_tokens(phase));
            if (phase == 0) hold_off_req = 1'b1;
            while (stim.size() < PHASE_ITEMS)
                build_line(($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 20), 1'b1);
            if ($urandom_range(0, 2) == 0) build_line($urandom_range(1, 12), 1'b0);
            send_stim();
            phase++;
        end
        drain();

        if (sb.errors == 0 && sb.expected_blocks.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/utf8bs_pkg.sv
hw/rtl/utf8bs_front.sv
hw/rtl/utf8bs_queue.sv
hw/rtl/utf8bs_back.sv
hw/rtl/utf8_block_segmenter.sv
bench/tb.sv
